// File: rtl/core/slc_pkg.sv
// ----------------------------------------------------------------------------
// slc_pkg
// Shared types for the schema literal classifier: character classes, the
// queue entry and the phase encodings of the three recognizers.
// ----------------------------------------------------------------------------
package slc_pkg;

  localparam int CharW = 8;
  localparam int OutDataW = 8;

  typedef enum logic [4:0] {
    CC_NONE     = 5'd0,
    CC_ZERO_ONE = 5'd1,
    CC_DIGIT    = 5'd2,
    CC_SIGN     = 5'd3,
    CC_DOT      = 5'd4,
    CC_UP_E     = 5'd5,
    CC_LOW_E    = 5'd6,
    CC_UP_N     = 5'd7,
    CC_LOW_A    = 5'd8,
    CC_UP_I     = 5'd9,
    CC_UP_F     = 5'd10,
    CC_LOW_F    = 5'd11,
    CC_LOW_L    = 5'd12,
    CC_LOW_S    = 5'd13,
    CC_LOW_T    = 5'd14,
    CC_LOW_R    = 5'd15,
    CC_LOW_U    = 5'd16,
    CC_OTHER    = 5'd17
  } char_class_t;

  typedef struct packed {
    char_class_t cls;
    logic        last;
  } slc_item_t;

  typedef enum logic [3:0] {
    IP_START  = 4'b0001,
    IP_SIGN   = 4'b0010,
    IP_DIGITS = 4'b0100,
    IP_DEAD   = 4'b1000
  } int_phase_t;

  typedef enum logic [10:0] {
    BS_START = 11'b000_0000_0001,
    BS_BIT   = 11'b000_0000_0010,
    BS_F     = 11'b000_0000_0100,
    BS_FA    = 11'b000_0000_1000,
    BS_FAL   = 11'b000_0001_0000,
    BS_FALS  = 11'b000_0010_0000,
    BS_FALSE = 11'b000_0100_0000,
    BS_T     = 11'b000_1000_0000,
    BS_TR    = 11'b001_0000_0000,
    BS_TRUE  = 11'b010_0000_0000,
    BS_DEAD  = 11'b100_0000_0000
  } bool_state_t;

  typedef enum logic [15:0] {
    DP_START    = 16'h0001,
    DP_SIGN     = 16'h0002,
    DP_INT      = 16'h0004,
    DP_INT_DOT  = 16'h0008,
    DP_FRAC     = 16'h0010,
    DP_DOT      = 16'h0020,
    DP_EXP      = 16'h0040,
    DP_EXP_SIGN = 16'h0080,
    DP_EXP_DIG  = 16'h0100,
    DP_N        = 16'h0200,
    DP_NA       = 16'h0400,
    DP_NAN      = 16'h0800,
    DP_I        = 16'h1000,
    DP_IN       = 16'h2000,
    DP_INF      = 16'h4000,
    DP_DEAD     = 16'h8000
  } dbl_phase_t;

endpackage

// File: rtl/core/slc_front.sv
// ----------------------------------------------------------------------------
// slc_front
// Input stage: takes one byte per transfer, maps it to a character class and
// holds it in a register until the queue takes it. Empty marks without last
// are dropped here.
// ----------------------------------------------------------------------------
module slc_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [slc_pkg::CharW-1:0] s_tdata,
  input  logic                      s_tlast,
  input  logic                      s_tuser,
  output logic                      f_valid,
  output slc_pkg::slc_item_t        f_item,
  input  logic                      q_ready
);
  import slc_pkg::*;

  char_class_t cls;

  always_comb begin
    if (s_tuser) begin
      cls = CC_NONE;
    end else begin
      case (s_tdata)
        8'h30, 8'h31: cls = CC_ZERO_ONE;
        8'h32, 8'h33, 8'h34, 8'h35,
        8'h36, 8'h37, 8'h38, 8'h39: cls = CC_DIGIT;
        8'h2B, 8'h2D: cls = CC_SIGN;
        8'h2E: cls = CC_DOT;
        8'h45: cls = CC_UP_E;
        8'h65: cls = CC_LOW_E;
        8'h4E: cls = CC_UP_N;
        8'h61: cls = CC_LOW_A;
        8'h49: cls = CC_UP_I;
        8'h46: cls = CC_UP_F;
        8'h66: cls = CC_LOW_F;
        8'h6C: cls = CC_LOW_L;
        8'h73: cls = CC_LOW_S;
        8'h74: cls = CC_LOW_T;
        8'h72: cls = CC_LOW_R;
        8'h75: cls = CC_LOW_U;
        default: cls = CC_OTHER;
      endcase
    end
  end

  assign s_tready = !f_valid || q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (s_tready) begin
      f_valid <= s_tvalid && !(s_tuser && !s_tlast);
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready) begin
      f_item.cls  <= cls;
      f_item.last <= s_tlast;
    end
  end

endmodule

// File: rtl/core/slc_queue.sv
// ----------------------------------------------------------------------------
// slc_queue
// Small register FIFO between the classifier stage and the recognizers.
// ----------------------------------------------------------------------------
module slc_queue #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  slc_pkg::slc_item_t push_item,
  output logic               ready,
  output logic               valid,
  output slc_pkg::slc_item_t pop_item,
  input  logic               pop
);
  import slc_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  slc_item_t       entries [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign ready    = count != CntFull;
  assign valid    = count != '0;
  assign pop_item = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrLast) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrLast) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> ready)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> valid)
    else $error("queue pop while empty");

endmodule

// File: rtl/core/slc_back.sv
// ----------------------------------------------------------------------------
// slc_back
// Runs the boolean, integer and double recognizers on classified characters
// and registers one verdict per token on the output channel.
// ----------------------------------------------------------------------------
module slc_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_valid,
  input  slc_pkg::slc_item_t           q_item,
  output logic                         q_pop,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [slc_pkg::OutDataW-1:0] m_tdata
);
  import slc_pkg::*;

  int_phase_t  iphase, iphase_next;
  bool_state_t bphase, bphase_next;
  dbl_phase_t  dphase, dphase_next;
  logic        digit, sign, expo;
  char_class_t c;

  assign c     = q_item.cls;
  assign digit = (c == CC_ZERO_ONE) || (c == CC_DIGIT);
  assign sign  = c == CC_SIGN;
  assign expo  = (c == CC_UP_E) || (c == CC_LOW_E);

  assign q_pop = q_valid && (!q_item.last || !m_tvalid || m_tready);

  always_comb begin
    case (iphase)
      IP_START: iphase_next = sign ? IP_SIGN : (digit ? IP_DIGITS : IP_DEAD);
      IP_SIGN, IP_DIGITS: iphase_next = digit ? IP_DIGITS : IP_DEAD;
      default: iphase_next = IP_DEAD;
    endcase
  end

  always_comb begin
    case (bphase)
      BS_START: begin
        if (c == CC_ZERO_ONE) bphase_next = BS_BIT;
        else if (c == CC_LOW_F) bphase_next = BS_F;
        else if (c == CC_LOW_T) bphase_next = BS_T;
        else bphase_next = BS_DEAD;
      end
      BS_F:    bphase_next = (c == CC_LOW_A) ? BS_FA : BS_DEAD;
      BS_FA:   bphase_next = (c == CC_LOW_L) ? BS_FAL : BS_DEAD;
      BS_FAL:  bphase_next = (c == CC_LOW_S) ? BS_FALS : BS_DEAD;
      BS_FALS: bphase_next = (c == CC_LOW_E) ? BS_FALSE : BS_DEAD;
      BS_T:    bphase_next = (c == CC_LOW_R) ? BS_TR : BS_DEAD;
      BS_TR:   bphase_next = (c == CC_LOW_U) ? BS_TRUE : BS_DEAD;
      default: bphase_next = BS_DEAD;
    endcase
  end

  always_comb begin
    case (dphase)
      DP_START, DP_SIGN: begin
        if ((dphase == DP_START) && sign) dphase_next = DP_SIGN;
        else if ((dphase == DP_START) && (c == CC_UP_N)) dphase_next = DP_N;
        else if (digit) dphase_next = DP_INT;
        else if (c == CC_DOT) dphase_next = DP_DOT;
        else if (c == CC_UP_I) dphase_next = DP_I;
        else dphase_next = DP_DEAD;
      end
      DP_INT: begin
        if (digit) dphase_next = DP_INT;
        else if (c == CC_DOT) dphase_next = DP_INT_DOT;
        else if (expo) dphase_next = DP_EXP;
        else dphase_next = DP_DEAD;
      end
      DP_INT_DOT, DP_FRAC: begin
        if (digit) dphase_next = DP_FRAC;
        else if (expo) dphase_next = DP_EXP;
        else dphase_next = DP_DEAD;
      end
      DP_DOT: dphase_next = digit ? DP_FRAC : DP_DEAD;
      DP_EXP: dphase_next = sign ? DP_EXP_SIGN : (digit ? DP_EXP_DIG : DP_DEAD);
      DP_EXP_SIGN, DP_EXP_DIG: dphase_next = digit ? DP_EXP_DIG : DP_DEAD;
      DP_N:  dphase_next = (c == CC_LOW_A) ? DP_NA : DP_DEAD;
      DP_NA: dphase_next = (c == CC_UP_N) ? DP_NAN : DP_DEAD;
      DP_I:  dphase_next = (c == CC_UP_N) ? DP_IN : DP_DEAD;
      DP_IN: dphase_next = (c == CC_UP_F) ? DP_INF : DP_DEAD;
      default: dphase_next = DP_DEAD;
    endcase
  end

  // phases after this character, or unchanged for an empty mark
  int_phase_t  iphase_upd;
  bool_state_t bphase_upd;
  dbl_phase_t  dphase_upd;

  assign iphase_upd = (c == CC_NONE) ? iphase : iphase_next;
  assign bphase_upd = (c == CC_NONE) ? bphase : bphase_next;
  assign dphase_upd = (c == CC_NONE) ? dphase : dphase_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      iphase   <= IP_START;
      bphase   <= BS_START;
      dphase   <= DP_START;
      m_tvalid <= 1'b0;
    end else begin
      if (q_pop) begin
        if (q_item.last) begin
          iphase <= IP_START;
          bphase <= BS_START;
          dphase <= DP_START;
        end else begin
          iphase <= iphase_upd;
          bphase <= bphase_upd;
          dphase <= dphase_upd;
        end
      end
      if (q_pop && q_item.last) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_item.last) begin
      m_tdata[0] <= (bphase_upd == BS_BIT) || (bphase_upd == BS_FALSE) ||
                    (bphase_upd == BS_TRUE);
      m_tdata[1] <= iphase_upd == IP_DIGITS;
      m_tdata[2] <= (dphase_upd == DP_INT) || (dphase_upd == DP_INT_DOT) ||
                    (dphase_upd == DP_FRAC) || (dphase_upd == DP_EXP_DIG) ||
                    (dphase_upd == DP_NAN) || (dphase_upd == DP_INF);
      m_tdata[OutDataW-1:3] <= '0;
    end
  end

  a_result_follows_last: assert property (@(posedge clk) disable iff (rst)
    q_pop && q_item.last |=> m_tvalid)
    else $error("token end gave no result");

  a_restart_after_last: assert property (@(posedge clk) disable iff (rst)
    q_pop && q_item.last |=>
      (iphase == IP_START) && (bphase == BS_START) && (dphase == DP_START))
    else $error("recognizers not restarted after token end");

  a_integer_is_double: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (!m_tdata[1] || m_tdata[2]))
    else $error("integer token not flagged as double");

endmodule

// File: rtl/core/schema_literal_classifier_core.sv
// ----------------------------------------------------------------------------
// schema_literal_classifier_core
// Lexical check of one text token as boolean, integer and double.
//
// Input stream: one token byte per transfer. s_tdata[7:0] is the byte,
// s_tlast marks the final byte, s_tuser marks an item with no byte (an empty
// token when s_tlast is set; ignored otherwise).
// Output stream: one transfer per token. m_tdata[0] boolean, [1] integer,
// [2] double, [7:3] zero.
// A byte is taken every cycle while s_tready is high. After the transfer
// carrying s_tlast is taken, it passes the front register and a queue entry
// before the result register raises m_tvalid.
// The queue of QUEUE_DEPTH entries lets the input keep running while the
// output is stalled; a stalled result holds only token ends, so bytes of the
// next token still flow until the queue fills, then s_tready drops.
// Reset returns all recognizers to the start of a token and empties the
// queue and the output register.
// ----------------------------------------------------------------------------
module schema_literal_classifier_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [slc_pkg::CharW-1:0]    s_tdata,   // [7:0] character
  input  logic                         s_tlast,
  input  logic                         s_tuser,   // [0] empty_token
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [slc_pkg::OutDataW-1:0] m_tdata    // [0] boolean_ok, [1] integer_ok,
                                                  // [2] double_ok, [7:3] zero
);
  import slc_pkg::*;

  logic      f_valid;
  slc_item_t f_item;
  logic      q_ready;
  logic      q_valid;
  slc_item_t q_item;
  logic      q_pop;

  slc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .s_tuser  (s_tuser),
    .f_valid  (f_valid),
    .f_item   (f_item),
    .q_ready  (q_ready)
  );

  slc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (f_valid && q_ready),
    .push_item (f_item),
    .ready     (q_ready),
    .valid     (q_valid),
    .pop_item  (q_item),
    .pop       (q_pop)
  );

  slc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// File: bench/tb_schema_literal_classifier_core.sv
// ----------------------------------------------------------------------------
// tb_schema_literal_classifier_core
// Self-checking bench for the token classifier. Token bytes are streamed in
// and each verdict is checked against a local model of the boolean, integer
// and double recognizers, or against the fixed verdict of a typed row in the
// short directed table that comes first. After it, random tokens follow:
// mostly well-formed ones, with broken tokens and noise mixed in. The run
// goes through phases of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_schema_literal_classifier_core;
  timeunit 1ns;
  timeprecision 1ps;

  import slc_pkg::*;

  typedef struct packed {
    logic [7:0] character;
    logic       last_char;
    logic       empty_token;
  } lex_item_t;

  typedef struct packed {
    logic [4:0] pad;
    logic       double_ok;
    logic       integer_ok;
    logic       boolean_ok;
  } verdict_t;

  typedef struct {
    lex_item_t it;
    bit        typed;
    verdict_t  want;
  } dir_row_t;

  localparam verdict_t V_NONE = 8'h00;
  localparam verdict_t V_BOOL = 8'h01;
  localparam verdict_t V_DBL  = 8'h04;
  localparam verdict_t V_ALL  = 8'h07;

  localparam string CharPool = "0123456789+-.eENaIFfalsetru";

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [CharW-1:0]    s_tdata;
  logic                s_tlast;
  logic                s_tuser;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;

  dbl_phase_t  dbl_ph  = DP_START;
  int_phase_t  int_ph  = IP_START;
  bool_state_t bool_ph = BS_START;

  verdict_t     verdict_q[$];
  dir_row_t     dir_rows[$];
  byte unsigned token_bytes[$];
  string        bool_words[4] = '{"0", "1", "false", "true"};

  int send_idle_pct = 0;
  int stall_pct = 0;
  int errors = 0;
  int items_sent = 0;
  int ignored_sent = 0;
  int tokens_sent = 0;
  int verdicts_checked = 0;
  int n_bool = 0;
  int n_int = 0;
  int n_dbl = 0;

  verdict_t want_v;
  verdict_t got_v;

  schema_literal_classifier_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // ---- recognizer model ----

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_sign(logic [7:0] c);
    return c == "+" || c == "-";
  endfunction

  function automatic bit is_exp(logic [7:0] c);
    return c == "E" || c == "e";
  endfunction

  function automatic dbl_phase_t next_dbl(dbl_phase_t p, logic [7:0] c);
    case (p)
      DP_START, DP_SIGN: begin
        if (p == DP_START && is_sign(c)) return DP_SIGN;
        if (p == DP_START && c == "N") return DP_N;
        if (is_digit(c)) return DP_INT;
        if (c == ".") return DP_DOT;
        return (c == "I") ? DP_I : DP_DEAD;
      end
      DP_INT: begin
        if (is_digit(c)) return DP_INT;
        if (c == ".") return DP_INT_DOT;
        return is_exp(c) ? DP_EXP : DP_DEAD;
      end
      DP_INT_DOT, DP_FRAC: begin
        if (is_digit(c)) return DP_FRAC;
        return is_exp(c) ? DP_EXP : DP_DEAD;
      end
      DP_DOT: return is_digit(c) ? DP_FRAC : DP_DEAD;
      DP_EXP: begin
        if (is_sign(c)) return DP_EXP_SIGN;
        return is_digit(c) ? DP_EXP_DIG : DP_DEAD;
      end
      DP_EXP_SIGN, DP_EXP_DIG: return is_digit(c) ? DP_EXP_DIG : DP_DEAD;
      DP_N: return (c == "a") ? DP_NA : DP_DEAD;
      DP_NA: return (c == "N") ? DP_NAN : DP_DEAD;
      DP_I: return (c == "N") ? DP_IN : DP_DEAD;
      DP_IN: return (c == "F") ? DP_INF : DP_DEAD;
      default: return DP_DEAD;
    endcase
  endfunction

  function automatic int_phase_t next_int(int_phase_t p, logic [7:0] c);
    case (p)
      IP_START: begin
        if (is_sign(c)) return IP_SIGN;
        return is_digit(c) ? IP_DIGITS : IP_DEAD;
      end
      IP_SIGN, IP_DIGITS: return is_digit(c) ? IP_DIGITS : IP_DEAD;
      default: return IP_DEAD;
    endcase
  endfunction

  function automatic bool_state_t next_bool(bool_state_t p, logic [7:0] c);
    case (p)
      BS_START: begin
        if (c == "0" || c == "1") return BS_BIT;
        if (c == "f") return BS_F;
        return (c == "t") ? BS_T : BS_DEAD;
      end
      BS_F: return (c == "a") ? BS_FA : BS_DEAD;
      BS_FA: return (c == "l") ? BS_FAL : BS_DEAD;
      BS_FAL: return (c == "s") ? BS_FALS : BS_DEAD;
      BS_FALS: return (c == "e") ? BS_FALSE : BS_DEAD;
      BS_T: return (c == "r") ? BS_TR : BS_DEAD;
      BS_TR: return (c == "u") ? BS_TRUE : BS_DEAD;
      default: return BS_DEAD;
    endcase
  endfunction

  // Advances the model by one item; returns 1 when the item closes a token.
  function automatic bit classify_item(input lex_item_t it, output verdict_t v);
    v = V_NONE;
    if (!it.empty_token) begin
      dbl_ph  = next_dbl(dbl_ph, it.character);
      int_ph  = next_int(int_ph, it.character);
      bool_ph = next_bool(bool_ph, it.character);
    end
    if (!it.last_char) return 1'b0;
    v.boolean_ok = (bool_ph == BS_BIT) || (bool_ph == BS_FALSE) || (bool_ph == BS_TRUE);
    v.integer_ok = (int_ph == IP_DIGITS);
    v.double_ok  = (dbl_ph == DP_INT) || (dbl_ph == DP_INT_DOT) || (dbl_ph == DP_FRAC) ||
                   (dbl_ph == DP_EXP_DIG) || (dbl_ph == DP_NAN) || (dbl_ph == DP_INF);
    dbl_ph  = DP_START;
    int_ph  = IP_START;
    bool_ph = BS_START;
    return 1'b1;
  endfunction

  // ---- directed table ----

  function automatic void add_raw(logic [7:0] c, bit last, bit empty, bit typed,
                                  verdict_t want);
    dir_row_t row;
    row.it = '{character: c, last_char: last, empty_token: empty};
    row.typed = typed;
    row.want = want;
    dir_rows.push_back(row);
  endfunction

  function automatic void add_text(string s, bit close, bit typed, verdict_t want);
    for (int i = 0; i < s.len(); i++)
      add_raw(s[i], close && (i == s.len() - 1), 1'b0, typed, want);
  endfunction

  // ---- token generation ----

  function automatic byte unsigned pick_char();
    if ($urandom_range(1) == 1) return CharPool[$urandom_range(CharPool.len() - 1)];
    return 8'($urandom_range(255));
  endfunction

  function automatic void push_word(string w);
    for (int i = 0; i < w.len(); i++) token_bytes.push_back(w[i]);
  endfunction

  function automatic void push_digits(int lo, int hi);
    repeat ($urandom_range(hi, lo)) token_bytes.push_back(8'("0" + $urandom_range(9)));
  endfunction

  function automatic void push_sign();
    case ($urandom_range(2))
      1: token_bytes.push_back("+");
      2: token_bytes.push_back("-");
      default: ;
    endcase
  endfunction

  function automatic void push_double();
    push_sign();
    if ($urandom_range(3) == 0) begin
      token_bytes.push_back(".");
      push_digits(1, 4);
    end else begin
      push_digits(1, 5);
      if ($urandom_range(1) == 1) begin
        token_bytes.push_back(".");
        push_digits(0, 3);
      end
    end
    if ($urandom_range(1) == 1) begin
      token_bytes.push_back(($urandom_range(1) == 1) ? "E" : "e");
      push_sign();
      push_digits(1, 3);
    end
  endfunction

  function automatic void build_token();
    int kind;
    int cut;
    kind = $urandom_range(99);
    token_bytes.delete();
    if (kind < 10) begin
      push_word(bool_words[$urandom_range(3)]);
    end else if (kind < 30) begin
      push_sign();
      push_digits(1, 6);
    end else if (kind < 60) begin
      push_double();
    end else if (kind < 66) begin
      push_sign();
      push_word(($urandom_range(1) == 1) ? "INF" : "NaN");
    end else if (kind < 82) begin
      // a valid literal with one defect
      if ($urandom_range(2) == 0) push_word(bool_words[$urandom_range(3)]);
      else if ($urandom_range(3) == 0) push_word(($urandom_range(1) == 1) ? "INF" : "NaN");
      else push_double();
      case ($urandom_range(2))
        0: token_bytes[$urandom_range(token_bytes.size() - 1)] = pick_char();
        1: begin
          cut = $urandom_range(token_bytes.size() - 1);
          while (token_bytes.size() > cut && token_bytes.size() > 1) void'(token_bytes.pop_back());
        end
        default: token_bytes.push_back(pick_char());
      endcase
    end else if (kind < 93) begin
      repeat ($urandom_range(5, 1)) token_bytes.push_back(pick_char());
    end
  endfunction

  // ---- stream driving ----

  task automatic send_item(input lex_item_t it, input bit typed, input verdict_t want);
    verdict_t v;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= it.character;
    s_tlast  <= it.last_char;
    s_tuser  <= it.empty_token;
    if (classify_item(it, v)) verdict_q.push_back(typed ? want : v);
    if (it.empty_token && !it.last_char) ignored_sent++;
    else items_sent++;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic emit_token();
    lex_item_t it;
    bit close_empty;
    close_empty = (token_bytes.size() == 0) || ($urandom_range(99) < 15);
    foreach (token_bytes[i]) begin
      if ($urandom_range(99) < 5) begin
        it = '{character: 8'($urandom_range(255)), last_char: 1'b0, empty_token: 1'b1};
        send_item(it, 1'b0, V_NONE);
      end
      it = '{character: token_bytes[i],
             last_char: !close_empty && (i == token_bytes.size() - 1),
             empty_token: 1'b0};
      send_item(it, 1'b0, V_NONE);
    end
    if (close_empty) begin
      it = '{character: 8'($urandom_range(255)), last_char: 1'b1, empty_token: 1'b1};
      send_item(it, 1'b0, V_NONE);
    end
    tokens_sent++;
  endtask

  task automatic hold_until_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (verdict_q.size() != 0) @(posedge clk);
  endtask

  // ---- result checking ----

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
    if (!rst && m_tvalid && m_tready) begin
      got_v = m_tdata;
      if (verdict_q.size() == 0) begin
        errors++;
        $display("%0t: verdict with none expected, expected none, got %b", $time, m_tdata);
      end else begin
        want_v = verdict_q.pop_front();
        check_field("boolean_ok", want_v.boolean_ok, got_v.boolean_ok);
        check_field("integer_ok", want_v.integer_ok, got_v.integer_ok);
        check_field("double_ok", want_v.double_ok, got_v.double_ok);
        check_field("pad bits", want_v.pad, got_v.pad);
        verdicts_checked++;
        n_bool += got_v.boolean_ok;
        n_int  += got_v.integer_ok;
        n_dbl  += got_v.double_ok;
      end
    end
  end

  // ---- main sequence ----

  int idle_tbl[4]  = '{0, 88, 0, 16};
  int stall_tbl[4] = '{0, 0, 88, 16};

  initial begin
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tlast  <= 1'b0;
    s_tuser  <= 1'b0;

    add_raw(8'h00, 1'b1, 1'b1, 1'b1, V_NONE);   // empty token
    add_text("0", 1'b1, 1'b1, V_ALL);
    add_raw(8'h00, 1'b1, 1'b0, 1'b1, V_NONE);   // zero byte
    add_raw(8'hFF, 1'b1, 1'b0, 1'b1, V_NONE);
    add_raw(8'hA5, 1'b0, 1'b1, 1'b0, V_NONE);   // empty mark, not last: ignored
    add_text("1", 1'b1, 1'b1, V_ALL);
    add_text("false", 1'b1, 1'b1, V_BOOL);
    add_text("-INF", 1'b1, 1'b1, V_DBL);
    add_text("NaN", 1'b1, 1'b1, V_DBL);
    add_text("7.", 1'b0, 1'b0, V_NONE);
    add_raw(8'h5A, 1'b1, 1'b1, 1'b0, V_NONE);   // token closed by empty mark
    add_text("-5e3", 1'b1, 1'b0, V_NONE);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);
    hold_until_drained();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_tbl[ph];
      stall_pct = stall_tbl[ph];
      while (items_sent < 25 + (ph + 1) * 250) begin
        build_token();
        emit_token();
      end
      hold_until_drained();
    end

    repeat (10) @(posedge clk);

    $display("Streamed %0d tokens: %0d characters or end marks, %0d ignored marks.",
             tokens_sent, items_sent, ignored_sent);
    $display("Checked %0d verdicts: %0d boolean, %0d integer, %0d double.",
             verdicts_checked, n_bool, n_int, n_dbl);
    if (errors == 0 && verdict_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
